/* rtl/tdzv_pkg.sv */
// Shared type codes and queue entry format for the typed delta zigzag varint encoder.
package tdzv_pkg;

    localparam logic [3:0] TYPE_UNKNOWN = 4'd0;
    localparam logic [3:0] TYPE_BOOL    = 4'd1;
    localparam logic [3:0] TYPE_I8      = 4'd2;
    localparam logic [3:0] TYPE_U8      = 4'd3;
    localparam logic [3:0] TYPE_I16     = 4'd4;
    localparam logic [3:0] TYPE_U16     = 4'd5;
    localparam logic [3:0] TYPE_I32     = 4'd6;
    localparam logic [3:0] TYPE_U32     = 4'd7;
    localparam logic [3:0] TYPE_I64     = 4'd8;
    localparam logic [3:0] TYPE_U64     = 4'd9;
    localparam logic [3:0] TYPE_F32     = 4'd10;
    localparam logic [3:0] TYPE_F64     = 4'd11;
    localparam logic [3:0] TYPE_CHAR    = 4'd12;

    localparam logic [2:0] RAW_LAST_F32 = 3'd3;
    localparam logic [2:0] RAW_LAST_F64 = 3'd7;

    // One classified change waiting for serialisation
    typedef struct packed {
        logic [63:0] value;
        logic        raw;
        logic [2:0]  last_idx;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* rtl/tdzv_front.sv */
// Front end: widens both values, forms the zigzag delta or selects raw float bits.
module tdzv_front
    import tdzv_pkg::*;
(
    input  logic [3:0]  new_type,
    input  logic [3:0]  old_type,
    input  logic [63:0] new_bits,
    input  logic [63:0] old_bits,
    output entry_t      entry
);

    function automatic logic [63:0] widen(input logic [3:0] code, input logic [63:0] bits);
        logic [63:0] w;
        begin
            case (code)
                TYPE_BOOL:           w = {63'd0, |bits[7:0]};
                TYPE_I8, TYPE_CHAR:  w = {{56{bits[7]}}, bits[7:0]};
                TYPE_U8:             w = {56'd0, bits[7:0]};
                TYPE_I16:            w = {{48{bits[15]}}, bits[15:0]};
                TYPE_U16:            w = {48'd0, bits[15:0]};
                TYPE_I32:            w = {{32{bits[31]}}, bits[31:0]};
                TYPE_U32:            w = {32'd0, bits[31:0]};
                TYPE_I64, TYPE_U64:  w = bits;
                default:             w = 64'd0;
            endcase
            return w;
        end
    endfunction

    logic [63:0] delta;
    logic [63:0] zigzag;

    assign delta  = widen(new_type, new_bits) - widen(old_type, old_bits);
    assign zigzag = {delta[62:0], 1'b0} ^ {64{delta[63]}};

    always_comb
    begin
        entry.value    = 64'd0;
        entry.raw      = 1'b0;
        entry.last_idx = 3'd0;
        if (new_type inside {[TYPE_BOOL:TYPE_U64], TYPE_CHAR})
        begin
            entry.value = zigzag;
        end
        else if (new_type == TYPE_F32)
        begin
            entry.value    = new_bits;
            entry.raw      = 1'b1;
            entry.last_idx = RAW_LAST_F32;
        end
        else if (new_type == TYPE_F64)
        begin
            entry.value    = new_bits;
            entry.raw      = 1'b1;
            entry.last_idx = RAW_LAST_F64;
        end
        // unknown types fall through as a varint of zero: one zero byte
    end

endmodule

/* rtl/tdzv_fifo.sv */
// Short register queue between the front end and the byte serialiser.
module tdzv_fifo
    import tdzv_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  entry_t       push_data,
    input  logic         pop,
    output entry_t       pop_data,
    output fifo_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/tdzv_back.sv */
// Back end: shifts one queued change out as LEB128 or raw bytes, one per cycle while out_ready allows.
module tdzv_back
    import tdzv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  fifo_status_t fifo_status,
    input  entry_t       fifo_data,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_byte,
    output logic         last_byte
);

    logic        busy_reg, busy_next;
    logic [63:0] value_reg, value_next;
    logic        raw_reg, raw_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        load_out;
    logic        cur_last;
    logic [7:0]  cur_byte;

    assign load_out = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (raw_reg)
        begin
            cur_last = (idx_reg == 3'd0);
            cur_byte = value_reg[7:0];
        end
        else
        begin
            cur_last = (value_reg[63:7] == 57'd0);
            cur_byte = {!cur_last, value_reg[6:0]};
        end
    end

    // Take the next change once the current one has handed over its final byte
    assign pop = !fifo_status.empty && (!busy_reg || (load_out && cur_last));

    always_comb
    begin
        busy_next      = busy_reg;
        value_next     = value_reg;
        raw_next       = raw_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            byte_next      = cur_byte;
            last_next      = cur_last;
            value_next     = raw_reg ? {8'd0, value_reg[63:8]} : {7'd0, value_reg[63:7]};
            idx_next       = idx_reg - 3'd1;
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            busy_next  = 1'b1;
            value_next = fifo_data.value;
            raw_next   = fifo_data.raw;
            idx_next   = fifo_data.last_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        raw_reg   <= raw_next;
        idx_reg   <= idx_next;
        byte_reg  <= byte_next;
        last_reg  <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = byte_reg;
    assign last_byte = last_reg;

endmodule

/* rtl/typed_delta_zigzag_varint_encoder_unit.sv */
// Top level of the typed delta zigzag varint encoder.
// Each accepted change is widened, differenced and zigzag mapped in the cycle it is
// accepted and parked in a FIFO_DEPTH-entry queue; the serialiser then emits one
// byte per cycle while out_ready is high: 1 to 10 LEB128 bytes for integer types,
// 4 or 8 raw little-endian bytes for f32/f64, one zero byte for unknown types.
// Throughput is therefore set by the single-byte output port: a change occupies the
// output for each of its bytes (up to 10), and consecutive queued changes follow
// with no gap between them. in_ready drops only when the queue is full. No
// reset-time clearing is needed.
module typed_delta_zigzag_varint_encoder_unit
    import tdzv_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  new_type,
    input  logic [3:0]  old_type,
    input  logic [63:0] new_bits,
    input  logic [63:0] old_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    entry_t       front_entry;
    entry_t       queue_head;
    fifo_status_t queue_status;
    logic         queue_pop;

    tdzv_front u_front (
        .new_type (new_type),
        .old_type (old_type),
        .new_bits (new_bits),
        .old_bits (old_bits),
        .entry    (front_entry)
    );

    tdzv_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_entry),
        .pop       (queue_pop),
        .pop_data  (queue_head),
        .status    (queue_status)
    );

    assign in_ready = !queue_status.full;

    tdzv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fifo_status (queue_status),
        .fifo_data   (queue_head),
        .pop         (queue_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_byte   (last_byte)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(queue_status.full && queue_status.empty))
        else $error("queue reports full and empty together");

    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !queue_status.empty)
        else $error("accepted transaction missing from queue");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_byte |=> out_valid)
        else $error("gap inside a change's byte stream");

endmodule

/* tb/tb_typed_delta_zigzag_varint_encoder_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the typed delta zigzag varint encoder unit.
module tb_typed_delta_zigzag_varint_encoder_unit;
    import tdzv_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RANDOM_CHANGES = 350;
    localparam int          DRAIN_EVERY    = 90;
    localparam int          SETTLE_CYCLES  = 20;
    localparam logic [3:0]  TYPE_SPARE_LO  = 4'd13;
    localparam logic [3:0]  TYPE_SPARE_HI  = 4'd15;
    localparam logic [63:0] LEB_GROUP_LIMIT = 64'h80;

    // One encoded output byte as the receiver sees it
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    // Directed change; gold_n of zero leaves the bytes to the predictor
    typedef struct packed {
        logic [3:0]  nt;
        logic [3:0]  ot;
        logic [63:0] nb;
        logic [63:0] ob;
        logic [3:0]  gold_n;
        logic [79:0] gold;
    } change_row_t;

    localparam int NUM_DIRECTED = 26;
    localparam change_row_t DIRECTED_CHANGES [NUM_DIRECTED] = '{
        // unknown and spare new types give a single zero byte
        '{TYPE_UNKNOWN, TYPE_I64, 64'h1234_5678_9ABC_DEF0, 64'h55, 4'd1, 80'h00},
        '{TYPE_SPARE_LO, TYPE_U8, 64'hFF, 64'h01, 4'd1, 80'h00},
        '{TYPE_SPARE_HI, TYPE_SPARE_HI, '1, '1, 4'd1, 80'h00},
        // floats: raw little-endian, upper bits and old value unused
        '{TYPE_F32, TYPE_I32, 64'hDEAD_BEEF_1122_3344, 64'h7, 4'd4, 80'h1122_3344},
        '{TYPE_F64, TYPE_I64, 64'h0102_0304_0506_0708, '1, 4'd8, 80'h0102_0304_0506_0708},
        '{TYPE_F32, TYPE_F64, 64'h0, 64'h0, 4'd4, 80'h0},
        // bool looks only at the low eight bits
        '{TYPE_BOOL, TYPE_UNKNOWN, 64'h1, 64'h0, 4'd1, 80'h02},
        '{TYPE_BOOL, TYPE_BOOL, 64'hFF00, 64'h1, 4'd1, 80'h01},
        '{TYPE_I64, TYPE_I64, 64'h0, 64'h0, 4'd1, 80'h00},
        '{TYPE_U64, TYPE_UNKNOWN, '1, 64'h0, 4'd1, 80'h01},
        // longest varints
        '{TYPE_I64, TYPE_UNKNOWN, 64'h8000_0000_0000_0000, 64'h0, 4'd10,
          80'h01_FF_FFFF_FFFF_FFFF_FFFF},
        '{TYPE_I64, TYPE_UNKNOWN, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 4'd10,
          80'h01_FFFF_FFFF_FFFF_FFFF_FE},
        // one-byte / two-byte boundary
        '{TYPE_I32, TYPE_UNKNOWN, 64'd63, 64'h0, 4'd1, 80'h7E},
        '{TYPE_I32, TYPE_UNKNOWN, 64'd64, 64'h0, 4'd2, 80'h0180},
        '{TYPE_I64, TYPE_I64, 64'h0, 64'h8000_0000_0000_0000, 4'd0, 80'h0},
        '{TYPE_U64, TYPE_U64, 64'h0, '1, 4'd0, 80'h0},
        // widening of each integer type, bits above the width ignored
        '{TYPE_I8, TYPE_U8, 64'hFFFF_0000_0000_0080, 64'h7F, 4'd0, 80'h0},
        '{TYPE_CHAR, TYPE_I8, 64'hFFFF_FFFF_FFFF_FF80, 64'h01, 4'd0, 80'h0},
        '{TYPE_U8, TYPE_I16, 64'hABCD_00FF, 64'h8000, 4'd0, 80'h0},
        '{TYPE_I16, TYPE_U16, 64'h1_8000, 64'hFFFF, 4'd0, 80'h0},
        '{TYPE_U16, TYPE_I32, 64'hFFFF, 64'h8000_0000, 4'd0, 80'h0},
        '{TYPE_I32, TYPE_U32, 64'h5_7FFF_FFFF, 64'hFFFF_FFFF, 4'd0, 80'h0},
        '{TYPE_U32, TYPE_CHAR, 64'hFFFF_FFFF, 64'h80, 4'd0, 80'h0},
        // float or unused old type counts as zero
        '{TYPE_I64, TYPE_F32, 64'h1234, 64'h3F80_0000, 4'd0, 80'h0},
        '{TYPE_U32, TYPE_F64, 64'h8000_0000, '1, 4'd0, 80'h0},
        '{TYPE_I16, 4'd14, 64'h8001, 64'h1234, 4'd0, 80'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  new_type;
    logic [3:0]  old_type;
    logic [63:0] new_bits;
    logic [63:0] old_bits;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        last_byte;

    enc_byte_t pending_bytes[$];
    int        error_count = 0;
    int        burst_left  = 0;

    typed_delta_zigzag_varint_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .new_type  (new_type),
        .old_type  (old_type),
        .new_bits  (new_bits),
        .old_bits  (old_bits),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Append one predicted byte to the tail of the expected stream
    task automatic expect_byte(input logic [7:0] data, input logic last);
        enc_byte_t b;
        b = enc_byte_t'{data: data, last: last};
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    function automatic logic [63:0] widen_value(input logic [3:0] t, input logic [63:0] v);
        case (t)
            TYPE_BOOL:          return {63'd0, |v[7:0]};
            TYPE_I8, TYPE_CHAR: return {{56{v[7]}}, v[7:0]};
            TYPE_U8:            return {56'd0, v[7:0]};
            TYPE_I16:           return {{48{v[15]}}, v[15:0]};
            TYPE_U16:           return {48'd0, v[15:0]};
            TYPE_I32:           return {{32{v[31]}}, v[31:0]};
            TYPE_U32:           return {32'd0, v[31:0]};
            TYPE_I64, TYPE_U64: return v;
            default:            return '0;
        endcase
    endfunction

    // Append the bytes one change should produce
    task automatic queue_encoded_bytes(input logic [3:0] nt, input logic [3:0] ot,
                                       input logic [63:0] nb, input logic [63:0] ob);
        logic [63:0] delta;
        logic [63:0] zz;
        int          raw_count;
        if ((nt >= TYPE_BOOL && nt <= TYPE_U64) || nt == TYPE_CHAR)
        begin
            delta = widen_value(nt, nb) - widen_value(ot, ob);
            zz    = {delta[62:0], 1'b0} ^ {64{delta[63]}};
            while (zz >= LEB_GROUP_LIMIT)
            begin
                expect_byte({1'b1, zz[6:0]}, 1'b0);
                zz = zz >> 7;
            end
            expect_byte(zz[7:0], 1'b1);
        end
        else if (nt == TYPE_F32 || nt == TYPE_F64)
        begin
            raw_count = (nt == TYPE_F32) ? 4 : 8;
            for (int k = 0; k < raw_count; k++)
                expect_byte(nb[8*k +: 8], (k == raw_count - 1));
        end
        else
        begin
            expect_byte(8'h00, 1'b1);
        end
    endtask

    // Drive one change in the current burst and hold it until the transaction completes
    task automatic send_change(input change_row_t row);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
        @(negedge clk);
        new_type <= row.nt;
        old_type <= row.ot;
        new_bits <= row.nb;
        old_bits <= row.ob;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (row.gold_n != 0)
        begin
            for (int k = 0; k < row.gold_n; k++)
                expect_byte(row.gold[8*k +: 8], (k == row.gold_n - 1));
        end
        else
        begin
            queue_encoded_bytes(row.nt, row.ot, row.nb, row.ob);
        end
    endtask

    // Hold the sender off until the encoder has emitted everything
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_bytes.size() != 0) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1:    return v;
            2:       return v & 64'hFF;
            3:       return v & 64'hFFFF;
            4:       return v & 64'hFFFF_FFFF;
            5:       return 64'd1 << $urandom_range(0, 63);
            6:       return ~(64'($urandom_range(0, 300)));
            default: return {v[63:9], 1'b0, 8'h80} ^ {{56{v[0]}}, 8'h00};
        endcase
    endfunction

    function automatic change_row_t random_change();
        change_row_t row;
        int          pick;
        row  = '0;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            row.nt = TYPE_UNKNOWN;
        else if (pick == 1)
            row.nt = 4'($urandom_range(TYPE_SPARE_HI, TYPE_SPARE_LO));
        else if (pick == 2)
            row.nt = TYPE_F32;
        else if (pick == 3)
            row.nt = TYPE_F64;
        else
        begin
            pick   = $urandom_range(0, 9);
            row.nt = (pick == 9) ? TYPE_CHAR : TYPE_BOOL + 4'(pick);
        end
        row.ot = 4'($urandom_range(0, 15));
        row.nb = rand_value();
        case ($urandom_range(0, 3))
            0:       row.ob = row.nb;
            1:       row.ob = row.nb - 64'd4 + 64'($urandom_range(0, 8));
            default: row.ob = rand_value();
        endcase
        return row;
    endfunction

    // Receiver back-pressure: stretches of different stall patterns
    initial
    begin
        int mode;
        int phase;
        out_ready = 1'b0;
        phase = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(8, 60))
            begin
                @(negedge clk);
                phase++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= (phase % 3 == 0);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h last=%0b with no change pending",
                                          out_byte, last_byte));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, predicted %02h",
                                              out_byte, want.data));
                if (last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %0b, predicted %0b",
                                              last_byte, want.last));
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        new_type = TYPE_UNKNOWN;
        old_type = TYPE_UNKNOWN;
        new_bits = '0;
        old_bits = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_change(DIRECTED_CHANGES[i]);
        hold_until_drained();

        for (int i = 0; i < RANDOM_CHANGES; i++)
        begin
            send_change(random_change());
            if (i % DRAIN_EVERY == DRAIN_EVERY - 1)
                hold_until_drained();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* typed_delta_zigzag_varint_encoder_unit.f */
rtl/tdzv_pkg.sv
rtl/tdzv_front.sv
rtl/tdzv_fifo.sv
rtl/tdzv_back.sv
rtl/typed_delta_zigzag_varint_encoder_unit.sv
tb/tb_typed_delta_zigzag_varint_encoder_unit.sv
